/* design/fmts_pkg.sv */
package fmts_pkg;

  // default counter width
  localparam int COUNT_BITS_DEF = 32;

  // byte cap after reset
  localparam logic [31:0] BYTE_CAP_RST = 32'd65536;

  // register map
  localparam logic REG_BYTE_CAP = 1'b0;

  // signature table geometry
  localparam int SIG_COUNT = 10;
  localparam int SIG_SPAN  = 12;
  localparam int POS_BITS  = 4;

  // signature slots in the match flags
  localparam int SIG_PNG      = 0;
  localparam int SIG_JPEG     = 1;
  localparam int SIG_GIF87    = 2;
  localparam int SIG_GIF89    = 3;
  localparam int SIG_BMP      = 4;
  localparam int SIG_PDF      = 5;
  localparam int SIG_WEBP     = 6;
  localparam int SIG_BOM8     = 7;
  localparam int SIG_BOM16LE  = 8;
  localparam int SIG_BOM16BE  = 9;

  // text rule: control bytes times this ratio must not exceed the byte count
  localparam int TEXT_RATIO = 50;

  // control bytes start below this value
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef enum logic [2:0] {
    FMT_PNG    = 3'd0,
    FMT_JPEG   = 3'd1,
    FMT_GIF    = 3'd2,
    FMT_BMP    = 3'd3,
    FMT_PDF    = 3'd4,
    FMT_WEBP   = 3'd5,
    FMT_TEXT   = 3'd6,
    FMT_BINARY = 3'd7
  } fmt_t;

  // magic bytes per signature, offset 0 first
  localparam logic [7:0] SIG_PAT [SIG_COUNT][SIG_SPAN] = '{
    '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hff, 8'hd8, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h42, 8'h4d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h57, 8'h45, 8'h42, 8'h50},
    '{8'hef, 8'hbb, 8'hbf, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hff, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hfe, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // offsets that must match, bit n for offset n
  localparam logic [SIG_SPAN-1:0] SIG_CARE [SIG_COUNT] = '{
    12'h0ff, 12'h007, 12'h03f, 12'h03f, 12'h003,
    12'h01f, 12'hf0f, 12'h007, 12'h003, 12'h003
  };

  // bytes needed before a signature can match
  localparam logic [POS_BITS-1:0] SIG_LEN [SIG_COUNT] = '{
    4'd8, 4'd3, 4'd6, 4'd6, 4'd2, 4'd5, 4'd12, 4'd3, 4'd2, 4'd2
  };

endpackage

/* design/fmts_scan.sv */
module fmts_scan #(
  parameter int COUNT_BITS = fmts_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [31:0]                     byte_cap,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_has_byte,
  input  logic                            in_last_byte,
  output logic                            snap_valid,
  input  logic                            snap_ready,
  output logic [COUNT_BITS-1:0]           snap_count,
  output logic [COUNT_BITS-1:0]           snap_ctrl,
  output logic [fmts_pkg::SIG_COUNT-1:0]  snap_flags,
  output logic                            snap_nul
);

  localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  logic                           s1_valid_r;
  logic [7:0]                     s1_byte_r;
  logic                           s1_has_r;
  logic                           s1_last_r;
  logic [COUNT_BITS-1:0]          cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0]          ctrl_r, ctrl_nxt;
  logic [fmts_pkg::SIG_COUNT-1:0] flags_r, flags_nxt;
  logic                           nul_r, nul_nxt;
  logic                           s1_go;
  logic                           take;
  logic                           early;
  logic                           is_ctrl;
  logic [fmts_pkg::POS_BITS-1:0]  pos_idx;

  // stage handshake: a beat with last waits for the snapshot register
  assign s1_go      = s1_valid_r && (!s1_last_r || snap_ready);
  assign in_ready   = !s1_valid_r || s1_go;
  assign snap_valid = s1_valid_r && s1_last_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // byte is counted while under the byte cap and the counter is not full
  assign take    = s1_valid_r && s1_has_r && (CMP_W'(cnt_r) < CMP_W'(byte_cap)) &&
                   (cnt_r != '1);
  assign early   = cnt_r < COUNT_BITS'(fmts_pkg::SIG_SPAN);
  assign pos_idx = cnt_r[fmts_pkg::POS_BITS-1:0];
  assign is_ctrl = (s1_byte_r < fmts_pkg::CTRL_LIMIT) &&
                   !(s1_byte_r inside {8'h0a, 8'h0d, 8'h09, 8'h0c, 8'h08});

  // next state after this beat's byte
  always_comb begin
    cnt_nxt   = cnt_r;
    ctrl_nxt  = ctrl_r;
    flags_nxt = flags_r;
    nul_nxt   = nul_r;
    if (take) begin
      cnt_nxt = cnt_r + 1'b1;
      if (s1_byte_r == 8'h00) begin
        nul_nxt = 1'b1;
      end
      if (is_ctrl && (ctrl_r != '1)) begin
        ctrl_nxt = ctrl_r + 1'b1;
      end
      // drop signatures contradicted at this offset
      if (early) begin
        for (int i = 0; i < fmts_pkg::SIG_COUNT; i++) begin
          if (fmts_pkg::SIG_CARE[i][pos_idx] &&
              (fmts_pkg::SIG_PAT[i][pos_idx] != s1_byte_r)) begin
            flags_nxt[i] = 1'b0;
          end
        end
      end
    end
  end

  assign snap_count = cnt_nxt;
  assign snap_ctrl  = ctrl_nxt;
  assign snap_flags = flags_nxt;
  assign snap_nul   = nul_nxt;

  // per-file state, cleared once the file is handed to the classifier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ctrl_r  <= '0;
      flags_r <= '1;
      nul_r   <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      cnt_r   <= '0;
      ctrl_r  <= '0;
      flags_r <= '1;
      nul_r   <= 1'b0;
    end else if (s1_go) begin
      cnt_r   <= cnt_nxt;
      ctrl_r  <= ctrl_nxt;
      flags_r <= flags_nxt;
      nul_r   <= nul_nxt;
    end
  end

endmodule

/* design/fmts_classify.sv */
module fmts_classify #(
  parameter int COUNT_BITS = fmts_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            snap_valid,
  output logic                            snap_ready,
  input  logic [COUNT_BITS-1:0]           snap_count,
  input  logic [COUNT_BITS-1:0]           snap_ctrl,
  input  logic [fmts_pkg::SIG_COUNT-1:0]  snap_flags,
  input  logic                            snap_nul,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_format_code,
  output logic [31:0]                     out_bytes_examined
);

  localparam int CMP_W  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int CTRL_W = COUNT_BITS + 6;

  logic                           s2_valid_r;
  logic [COUNT_BITS-1:0]          s2_cnt_r;
  logic [COUNT_BITS-1:0]          s2_ctrl_r;
  logic [fmts_pkg::SIG_COUNT-1:0] s2_flags_r;
  logic                           s2_nul_r;
  logic                           out_valid_r;
  fmts_pkg::fmt_t                 code_r, code_nxt;
  logic [31:0]                    bytes_r, bytes_nxt;
  logic                           s2_go;
  logic [fmts_pkg::SIG_COUNT-1:0] hit;
  logic [CTRL_W-1:0]              ctrl_scaled;
  logic                           text_ok;
  logic [CMP_W-1:0]               cnt_ext;

  assign s2_go      = s2_valid_r && (!out_valid_r || out_ready);
  assign snap_ready = !s2_valid_r || s2_go;

  // snapshot register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (snap_ready) begin
      s2_valid_r <= snap_valid;
    end
    if (snap_valid && snap_ready) begin
      s2_cnt_r   <= snap_count;
      s2_ctrl_r  <= snap_ctrl;
      s2_flags_r <= snap_flags;
      s2_nul_r   <= snap_nul;
    end
  end

  // a signature hits once enough bytes were seen and none contradicted it
  always_comb begin
    for (int i = 0; i < fmts_pkg::SIG_COUNT; i++) begin
      hit[i] = s2_flags_r[i] && (s2_cnt_r >= COUNT_BITS'(fmts_pkg::SIG_LEN[i]));
    end
  end

  // control density test without a divider
  assign ctrl_scaled = CTRL_W'(s2_ctrl_r) * CTRL_W'(fmts_pkg::TEXT_RATIO);
  assign text_ok     = ctrl_scaled <= CTRL_W'(s2_cnt_r);

  // priority decode
  always_comb begin
    if (hit[fmts_pkg::SIG_PNG]) begin
      code_nxt = fmts_pkg::FMT_PNG;
    end else if (hit[fmts_pkg::SIG_JPEG]) begin
      code_nxt = fmts_pkg::FMT_JPEG;
    end else if (hit[fmts_pkg::SIG_GIF87] || hit[fmts_pkg::SIG_GIF89]) begin
      code_nxt = fmts_pkg::FMT_GIF;
    end else if (hit[fmts_pkg::SIG_BMP]) begin
      code_nxt = fmts_pkg::FMT_BMP;
    end else if (hit[fmts_pkg::SIG_PDF]) begin
      code_nxt = fmts_pkg::FMT_PDF;
    end else if (hit[fmts_pkg::SIG_WEBP]) begin
      code_nxt = fmts_pkg::FMT_WEBP;
    end else if (s2_cnt_r == '0) begin
      code_nxt = fmts_pkg::FMT_TEXT;
    end else if (hit[fmts_pkg::SIG_BOM8] || hit[fmts_pkg::SIG_BOM16LE] ||
                 hit[fmts_pkg::SIG_BOM16BE]) begin
      code_nxt = fmts_pkg::FMT_TEXT;
    end else if (s2_nul_r) begin
      code_nxt = fmts_pkg::FMT_BINARY;
    end else if (text_ok) begin
      code_nxt = fmts_pkg::FMT_TEXT;
    end else begin
      code_nxt = fmts_pkg::FMT_BINARY;
    end
  end

  // byte count clipped to 32 bits
  assign cnt_ext   = CMP_W'(s2_cnt_r);
  assign bytes_nxt = (cnt_ext > CMP_W'(32'hffff_ffff)) ? 32'hffff_ffff : cnt_ext[31:0];

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s2_go) begin
      code_r  <= code_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_format_code    = code_r;
  assign out_bytes_examined = bytes_r;

endmodule

/* design/file_format_sniffer_unit.sv */
// File type sniffer. Feed a file's leading bytes one beat per cycle from
// offset zero, and mark the final beat with last_byte (a beat with has_byte low
// and last_byte high classifies an empty file). The unit takes one beat every
// cycle unless stalled; each beat only updates small counters and signature
// flags in the scan stage. The beat carrying last_byte passes the input
// register, the snapshot register and the result register, so its result is
// valid once it reaches the result register. The next file's first beat may
// enter as that last beat moves on. While a result is held off, a last beat
// waits in the input register and stalls further input.
// Bytes beyond byte_cap (APB offset 0x0, reset 65536) are not counted;
// write it only while no file is in flight.
module file_format_sniffer_unit #(
  parameter int COUNT_BITS = fmts_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  // classification result
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_format_code,
  output logic [31:0] out_bytes_examined
);

  logic [31:0]                    byte_cap_r;
  logic                           snap_valid;
  logic                           snap_ready;
  logic [COUNT_BITS-1:0]          snap_count;
  logic [COUNT_BITS-1:0]          snap_ctrl;
  logic [fmts_pkg::SIG_COUNT-1:0] snap_flags;
  logic                           snap_nul;
  logic                           reg_sel;

  // register decode
  assign reg_sel = (paddr[2] == fmts_pkg::REG_BYTE_CAP);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? byte_cap_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cap_r <= fmts_pkg::BYTE_CAP_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      byte_cap_r <= pwdata;
    end
  end

  fmts_scan #(
    .COUNT_BITS(COUNT_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_cap     (byte_cap_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_last_byte (in_last_byte),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap_count   (snap_count),
    .snap_ctrl    (snap_ctrl),
    .snap_flags   (snap_flags),
    .snap_nul     (snap_nul)
  );

  fmts_classify #(
    .COUNT_BITS(COUNT_BITS)
  ) u_classify (
    .clk                (clk),
    .rst_n              (rst_n),
    .snap_valid         (snap_valid),
    .snap_ready         (snap_ready),
    .snap_count         (snap_count),
    .snap_ctrl          (snap_ctrl),
    .snap_flags         (snap_flags),
    .snap_nul           (snap_nul),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_format_code    (out_format_code),
    .out_bytes_examined (out_bytes_examined)
  );

endmodule

/* design/fmts_checker.sv */
module fmts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_format_code,
  input logic [31:0] out_bytes_examined
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_format_code) &&
      $stable(out_bytes_examined))
    else $error("result beat changed while stalled");

  // no result right out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // png needs its full eight-byte signature
  a_png_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_format_code == fmts_pkg::FMT_PNG) |-> out_bytes_examined >= 32'd8)
    else $error("png reported on a short file");

  // webp needs at least twelve bytes
  a_webp_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_format_code == fmts_pkg::FMT_WEBP) |-> out_bytes_examined >= 32'd12)
    else $error("webp reported on a short file");

endmodule

bind file_format_sniffer_unit fmts_checker u_fmts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_format_code    (out_format_code),
  .out_bytes_examined (out_bytes_examined)
);
